// File: hdl/mtl_pkg.sv
// Shared types and constants for the median threshold lap detector.
`default_nettype none
package mtl_pkg;

    localparam int SAMPLE_W = 16;
    localparam int TIME_W = 32;
    localparam int COUNT_W = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTER_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAVE_LIMIT = 2'd2;

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 16'd36100;
    localparam logic [COUNT_W-1:0] ENTER_LIMIT_RESET = 16'd200;
    localparam logic [COUNT_W-1:0] LEAVE_LIMIT_RESET = 16'd20000;
    localparam logic [COUNT_W-1:0] COUNT_TOP = 16'hFFFF;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic le;
    } cell_view_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] level_threshold;
        logic [COUNT_W-1:0] enter_limit;
        logic [COUNT_W-1:0] leave_limit;
    } cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] filtered_level;
        logic new_lap;
        logic [TIME_W-1:0] lap_time_ms;
        logic inside_checkpoint;
    } lap_result_t;

endpackage
`default_nettype wire

// File: hdl/median_threshold_lap_detector.sv
// Top level of the running median checkpoint detector with lap reporting.
// A sample is sorted into the cell chain in the cycle of its transfer; its
// result is registered into the output register when the stage advances.
// Throughput is one sample per cycle while out_ready does not stall the output.
// Reset clears the window to zeros, the counters and the checkpoint state,
// and loads the registers with their default values.
`default_nettype none
module median_threshold_lap_detector #(
    parameter int WINDOW_LEN = 5
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_ready,
    input  wire logic [15:0] sample,
    input  wire logic [31:0] timestamp_ms,
    output logic out_valid,
    input  wire logic out_ready,
    output logic [15:0] filtered_level,
    output logic new_lap,
    output logic [31:0] lap_time_ms,
    output logic inside_checkpoint,
    input  wire logic cfg_valid,
    output logic cfg_ready,
    input  wire logic [mtl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int AGE_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int MID = WINDOW_LEN / 2;

    mtl_pkg::cfg_t cfg_reg;
    logic s1_valid_reg;
    logic [mtl_pkg::TIME_W-1:0] s1_time_reg;
    logic out_valid_reg;
    mtl_pkg::lap_result_t result_reg;
    mtl_pkg::lap_result_t result_next;
    logic accept_in;
    logic step;

    mtl_pkg::cell_view_t own_view [WINDOW_LEN];
    logic [AGE_W-1:0] own_age [WINDOW_LEN];
    mtl_pkg::cell_view_t left_view [WINDOW_LEN];
    logic [AGE_W-1:0] left_age [WINDOW_LEN];
    mtl_pkg::cell_view_t right_view [WINDOW_LEN];
    logic [AGE_W-1:0] right_age [WINDOW_LEN];
    logic [WINDOW_LEN-1:0] del_in;
    logic [WINDOW_LEN-1:0] del_out;
    logic [WINDOW_LEN-1:0] oldest_vec;

    assign cfg_ready = 1'b1;
    assign step = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || step;
    assign accept_in = in_valid && in_ready;

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_LEN; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                assign left_view[gi] = '0;
                assign left_age[gi] = '0;
                assign del_in[gi] = 1'b0;
            end
            else
            begin : g_inner_left
                assign left_view[gi] = own_view[gi-1];
                assign left_age[gi] = own_age[gi-1];
                assign del_in[gi] = del_out[gi-1];
            end
            if (gi == WINDOW_LEN - 1)
            begin : g_last
                assign right_view[gi] = '0;
                assign right_age[gi] = '0;
            end
            else
            begin : g_inner_right
                assign right_view[gi] = own_view[gi+1];
                assign right_age[gi] = own_age[gi+1];
            end
            assign oldest_vec[gi] = del_out[gi] & ~del_in[gi];

            mtl_cell #(
                .AGE_W(AGE_W),
                .RESET_AGE(gi),
                .OLDEST_AGE(WINDOW_LEN - 1),
                .HAS_LEFT((gi > 0) ? 1 : 0),
                .HAS_RIGHT((gi < WINDOW_LEN - 1) ? 1 : 0)
            ) u_cell (
                .clk(clk),
                .rst_n(rst_n),
                .shift_en(accept_in),
                .sample(sample),
                .left_view(left_view[gi]),
                .left_age(left_age[gi]),
                .right_view(right_view[gi]),
                .right_age(right_age[gi]),
                .del_in(del_in[gi]),
                .del_out(del_out[gi]),
                .own_view(own_view[gi]),
                .own_age(own_age[gi])
            );
        end
    endgenerate

    mtl_lap_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .step(step),
        .median(own_view[MID].value),
        .timestamp(s1_time_reg),
        .cfg(cfg_reg),
        .result(result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.level_threshold <= mtl_pkg::THRESHOLD_RESET;
            cfg_reg.enter_limit <= mtl_pkg::ENTER_LIMIT_RESET;
            cfg_reg.leave_limit <= mtl_pkg::LEAVE_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mtl_pkg::CFG_LEVEL_THRESHOLD: cfg_reg.level_threshold <= cfg_data;
                mtl_pkg::CFG_ENTER_LIMIT: cfg_reg.enter_limit <= cfg_data;
                mtl_pkg::CFG_LEAVE_LIMIT: cfg_reg.leave_limit <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept_in || (s1_valid_reg && !step);
            out_valid_reg <= step || (out_valid_reg && !out_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            s1_time_reg <= timestamp_ms;
        end
        if (step)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign filtered_level = result_reg.filtered_level;
    assign new_lap = result_reg.new_lap;
    assign lap_time_ms = result_reg.lap_time_ms;
    assign inside_checkpoint = result_reg.inside_checkpoint;

    a_one_oldest: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(oldest_vec))
        else $error("The cell chain does not hold exactly one oldest entry.");

    a_lap_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && new_lap) |-> inside_checkpoint)
        else $error("A lap was reported without entering the checkpoint.");

    a_no_lap_time: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !new_lap) |-> (lap_time_ms == '0))
        else $error("A lap time was reported without a lap.");

    a_window_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (own_view[0].value <= own_view[WINDOW_LEN-1].value))
        else $error("The cell chain lost its ascending order.");

endmodule
`default_nettype wire

// File: hdl/mtl_cell.sv
// One cell of the sorted window chain: holds one sample and its age.
`default_nettype none
module mtl_cell #(
    parameter int AGE_W = 3,
    parameter int RESET_AGE = 0,
    parameter int OLDEST_AGE = 4,
    parameter int HAS_LEFT = 1,
    parameter int HAS_RIGHT = 1
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic shift_en,
    input  wire logic [mtl_pkg::SAMPLE_W-1:0] sample,
    input  wire mtl_pkg::cell_view_t left_view,
    input  wire logic [AGE_W-1:0] left_age,
    input  wire mtl_pkg::cell_view_t right_view,
    input  wire logic [AGE_W-1:0] right_age,
    input  wire logic del_in,
    output logic del_out,
    output mtl_pkg::cell_view_t own_view,
    output logic [AGE_W-1:0] own_age
);

    logic [mtl_pkg::SAMPLE_W-1:0] value_reg;
    logic [mtl_pkg::SAMPLE_W-1:0] value_next;
    logic [AGE_W-1:0] age_reg;
    logic [AGE_W-1:0] age_next;
    mtl_pkg::cell_view_t low_view;
    logic [AGE_W-1:0] low_age;
    mtl_pkg::cell_view_t high_view;
    logic [AGE_W-1:0] high_age;

    assign own_view.value = value_reg;
    assign own_view.le = (value_reg <= sample);
    assign own_age = age_reg;
    assign del_out = del_in | (age_reg == AGE_W'(OLDEST_AGE));

    // The oldest entry is dropped and the rest close up; each cell then takes
    // the entry that lands on it once the new sample is placed in order.
    always_comb
    begin
        low_view = del_out ? right_view : own_view;
        low_age = del_out ? right_age : age_reg;
        high_view = del_in ? own_view : left_view;
        high_age = del_in ? age_reg : left_age;
        if ((HAS_RIGHT != 0) && low_view.le)
        begin
            value_next = low_view.value;
            age_next = low_age + AGE_W'(1);
        end
        else if ((HAS_LEFT != 0) && !high_view.le)
        begin
            value_next = high_view.value;
            age_next = high_age + AGE_W'(1);
        end
        else
        begin
            value_next = sample;
            age_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
            age_reg <= AGE_W'(RESET_AGE);
        end
        else if (shift_en)
        begin
            value_reg <= value_next;
            age_reg <= age_next;
        end
    end

endmodule
`default_nettype wire

// File: hdl/mtl_lap_ctrl.sv
// Hysteresis counters and checkpoint state driven by the window median.
`default_nettype none
module mtl_lap_ctrl (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic step,
    input  wire logic [mtl_pkg::SAMPLE_W-1:0] median,
    input  wire logic [mtl_pkg::TIME_W-1:0] timestamp,
    input  wire mtl_pkg::cfg_t cfg,
    output mtl_pkg::lap_result_t result
);

    logic inside_reg;
    logic inside_next;
    logic [mtl_pkg::COUNT_W-1:0] enter_count_reg;
    logic [mtl_pkg::COUNT_W-1:0] enter_count_next;
    logic [mtl_pkg::COUNT_W-1:0] leave_count_reg;
    logic [mtl_pkg::COUNT_W-1:0] leave_count_next;
    logic [mtl_pkg::COUNT_W-1:0] enter_bumped;
    logic [mtl_pkg::COUNT_W-1:0] leave_bumped;
    logic lap;

    always_comb
    begin
        enter_bumped = (enter_count_reg == mtl_pkg::COUNT_TOP) ? enter_count_reg
                                                             : enter_count_reg + 16'd1;
        leave_bumped = (leave_count_reg == mtl_pkg::COUNT_TOP) ? leave_count_reg
                                                             : leave_count_reg + 16'd1;
        inside_next = inside_reg;
        enter_count_next = enter_count_reg;
        leave_count_next = leave_count_reg;
        lap = 1'b0;
        if ((median > cfg.level_threshold) && !inside_reg)
        begin
            if (enter_bumped > cfg.enter_limit)
            begin
                inside_next = 1'b1;
                lap = 1'b1;
                enter_count_next = '0;
                leave_count_next = '0;
            end
            else
            begin
                enter_count_next = enter_bumped;
            end
        end
        else if ((median < cfg.level_threshold) && inside_reg)
        begin
            if (leave_bumped > cfg.leave_limit)
            begin
                inside_next = 1'b0;
                enter_count_next = '0;
                leave_count_next = '0;
            end
            else
            begin
                leave_count_next = leave_bumped;
            end
        end
        result.filtered_level = median;
        result.new_lap = lap;
        result.lap_time_ms = lap ? timestamp : '0;
        result.inside_checkpoint = inside_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg <= 1'b0;
            enter_count_reg <= '0;
            leave_count_reg <= '0;
        end
        else if (step)
        begin
            inside_reg <= inside_next;
            enter_count_reg <= enter_count_next;
            leave_count_reg <= leave_count_next;
        end
    end

endmodule
`default_nettype wire
